// File: src/sdcp_pkg.sv
// Shared types, constants and helpers for the serial drive-command parser.
// No dependencies.
package sdcp_pkg;

	localparam int FRAME_BYTES_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CENTER_RESET = 8'd90;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int PREFIX_LEN = 5;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_DRIVE = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	// one request handed from the front to the back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] speed;
		logic [7:0] angle;
	} rec_t;

	// number scanner phases
	typedef enum logic [6:0] {
		NP_START1 = 7'b0000001,
		NP_SIGN1  = 7'b0000010,
		NP_NUM1   = 7'b0000100,
		NP_START2 = 7'b0001000,
		NP_SIGN2  = 7'b0010000,
		NP_NUM2   = 7'b0100000,
		NP_DONE   = 7'b1000000
	} np_t;

	typedef struct packed {
		logic neg1;
		logic valid1;
		logic neg2;
		logic valid2;
		logic ended;
	} flags_t;

	function automatic logic [7:0] cmd_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'h23; // '#'
			3'd1: r = 8'h43; // 'C'
			3'd2: r = 8'h4D; // 'M'
			3'd3: r = 8'h44; // 'D'
			3'd4: r = 8'h2C; // ','
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] stop_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'h23; // '#'
			3'd1: r = 8'h53; // 'S'
			3'd2: r = 8'h54; // 'T'
			3'd3: r = 8'h4F; // 'O'
			3'd4: r = 8'h50; // 'P'
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// acc*10 + digit, wrapping at 8 bits
	function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
		logic [7:0] r;
		r = (acc << 3) + (acc << 1) + (c - CH_ZERO);
		return r;
	endfunction

endpackage

// File: src/sdcp_front.sv
// Front end: byte filter, frame length, prefix match and number scanner.
// Depends on sdcp_pkg. Emits one request per accepted '*' unless the frame is full.
module sdcp_front #(
	parameter int FRAME_BYTES = sdcp_pkg::FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_ready,
	input  logic [7:0]        byte_data,
	input  logic [7:0]        center_angle,
	output logic              push,
	output sdcp_pkg::rec_t    push_rec
);

	localparam int LenW = $clog2(FRAME_BYTES);
	localparam logic [LenW-1:0] LenMax = LenW'(FRAME_BYTES - 1);
	localparam logic [LenW-1:0] LenPfx = LenW'(sdcp_pkg::PREFIX_LEN);

	logic [LenW-1:0]  len_q, len_n;
	logic             pf_cmd_q, pf_cmd_n;
	logic             pf_stop_q, pf_stop_n;
	sdcp_pkg::np_t    np_q, np_n;
	logic [7:0]       spd_q, spd_n;
	logic [7:0]       ang_q, ang_n;
	sdcp_pkg::flags_t fl_q, fl_n;

	logic acc;
	logic in_pfx;
	logic dig;

	assign acc    = byte_valid && byte_ready;
	assign in_pfx = len_q < LenPfx;
	assign dig    = sdcp_pkg::is_digit(byte_data);

	// result candidate from the current frame state
	always_comb begin
		push_rec = '0;
		if (!in_pfx && pf_cmd_q) begin
			push_rec.kind  = sdcp_pkg::KIND_DRIVE;
			push_rec.speed = 8'd0;
			push_rec.angle = center_angle;
			if (fl_q.valid1) begin
				push_rec.speed = fl_q.neg1 ? (8'd0 - spd_q) : spd_q;
				if (fl_q.valid2)
					push_rec.angle = fl_q.neg2 ? (8'd0 - ang_q) : ang_q;
			end
		end else if (!in_pfx && pf_stop_q) begin
			push_rec.kind = sdcp_pkg::KIND_STOP;
		end else begin
			push_rec.kind = sdcp_pkg::KIND_NONE;
		end
	end

	always_comb begin
		len_n     = len_q;
		pf_cmd_n  = pf_cmd_q;
		pf_stop_n = pf_stop_q;
		np_n      = np_q;
		spd_n     = spd_q;
		ang_n     = ang_q;
		fl_n      = fl_q;
		push      = 1'b0;
		if (acc && byte_data != sdcp_pkg::CH_LF && byte_data != sdcp_pkg::CH_CR) begin
			if (len_q == LenMax || byte_data == sdcp_pkg::CH_STAR) begin
				// full frame drops the byte; '*' closes the frame
				push      = (len_q != LenMax);
				len_n     = '0;
				pf_cmd_n  = 1'b1;
				pf_stop_n = 1'b1;
				np_n      = sdcp_pkg::NP_START1;
				spd_n     = 8'd0;
				ang_n     = 8'd0;
				fl_n      = '0;
			end else begin
				len_n = len_q + LenW'(1);
				if (!fl_q.ended) begin
					if (byte_data == sdcp_pkg::CH_NUL) begin
						fl_n.ended = 1'b1;
						if (in_pfx) begin
							pf_cmd_n  = 1'b0;
							pf_stop_n = 1'b0;
						end
					end else if (in_pfx) begin
						pf_cmd_n  = pf_cmd_q && (byte_data == sdcp_pkg::cmd_char(len_q[2:0]));
						pf_stop_n = pf_stop_q && (byte_data == sdcp_pkg::stop_char(len_q[2:0]));
					end else if (pf_cmd_q) begin
						unique case (np_q)
							sdcp_pkg::NP_START1, sdcp_pkg::NP_START2: begin
								if (sdcp_pkg::is_space(byte_data)) begin
									np_n = np_q;
								end else if (byte_data == sdcp_pkg::CH_PLUS ||
								             byte_data == sdcp_pkg::CH_MINUS) begin
									if (np_q == sdcp_pkg::NP_START2) begin
										fl_n.neg2 = fl_q.neg2 || (byte_data == sdcp_pkg::CH_MINUS);
										np_n      = sdcp_pkg::NP_SIGN2;
									end else begin
										fl_n.neg1 = fl_q.neg1 || (byte_data == sdcp_pkg::CH_MINUS);
										np_n      = sdcp_pkg::NP_SIGN1;
									end
								end else if (dig) begin
									if (np_q == sdcp_pkg::NP_START2) begin
										ang_n       = sdcp_pkg::acc_digit(ang_q, byte_data);
										fl_n.valid2 = 1'b1;
										np_n        = sdcp_pkg::NP_NUM2;
									end else begin
										spd_n       = sdcp_pkg::acc_digit(spd_q, byte_data);
										fl_n.valid1 = 1'b1;
										np_n        = sdcp_pkg::NP_NUM1;
									end
								end else begin
									np_n = sdcp_pkg::NP_DONE;
								end
							end
							sdcp_pkg::NP_SIGN1: begin
								if (dig) begin
									spd_n       = sdcp_pkg::acc_digit(spd_q, byte_data);
									fl_n.valid1 = 1'b1;
									np_n        = sdcp_pkg::NP_NUM1;
								end else begin
									np_n = sdcp_pkg::NP_DONE;
								end
							end
							sdcp_pkg::NP_SIGN2: begin
								if (dig) begin
									ang_n       = sdcp_pkg::acc_digit(ang_q, byte_data);
									fl_n.valid2 = 1'b1;
									np_n        = sdcp_pkg::NP_NUM2;
								end else begin
									np_n = sdcp_pkg::NP_DONE;
								end
							end
							sdcp_pkg::NP_NUM1: begin
								if (dig)
									spd_n = sdcp_pkg::acc_digit(spd_q, byte_data);
								else if (byte_data == sdcp_pkg::CH_COMMA)
									np_n = sdcp_pkg::NP_START2;
								else
									np_n = sdcp_pkg::NP_DONE;
							end
							sdcp_pkg::NP_NUM2: begin
								if (dig)
									ang_n = sdcp_pkg::acc_digit(ang_q, byte_data);
								else
									np_n = sdcp_pkg::NP_DONE;
							end
							default: np_n = sdcp_pkg::NP_DONE;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			pf_cmd_q  <= 1'b1;
			pf_stop_q <= 1'b1;
			np_q      <= sdcp_pkg::NP_START1;
			spd_q     <= 8'd0;
			ang_q     <= 8'd0;
			fl_q      <= '0;
		end else begin
			len_q     <= len_n;
			pf_cmd_q  <= pf_cmd_n;
			pf_stop_q <= pf_stop_n;
			np_q      <= np_n;
			spd_q     <= spd_n;
			ang_q     <= ang_n;
			fl_q      <= fl_n;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenMax)
		else $error("frame length past limit");

	a_star_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && byte_data == sdcp_pkg::CH_STAR |=> len_q == '0)
		else $error("frame not restarted after '*'");

	a_drive_len: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_rec.kind == sdcp_pkg::KIND_DRIVE |-> !in_pfx && pf_cmd_q)
		else $error("drive request from short or mismatched frame");

endmodule

// File: src/sdcp_queue.sv
// Short register queue between front and back ends.
// Depends on sdcp_pkg for the request type.
module sdcp_queue #(
	parameter int DEPTH = sdcp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sdcp_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output sdcp_pkg::rec_t pop_rec
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	sdcp_pkg::rec_t  mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntFull);
	assign not_empty = (cnt_q != '0);
	assign pop_rec   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
			if (pop)
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

// File: src/sdcp_back.sv
// Back end: applies requests to the held speed and angle and drives results.
// Depends on sdcp_pkg.
module sdcp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  sdcp_pkg::rec_t req,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output sdcp_pkg::kind_t res_kind,
	output logic [7:0]     res_speed,
	output logic [7:0]     res_angle
);

	logic       vld_q;
	logic [7:0] held_spd_q, held_ang_q;
	logic [7:0] spd_n, ang_n;

	assign pop       = req_valid && (!vld_q || res_ready);
	assign res_valid = vld_q;

	always_comb begin
		spd_n = held_spd_q;
		ang_n = held_ang_q;
		unique case (req.kind)
			sdcp_pkg::KIND_DRIVE: begin
				spd_n = req.speed;
				ang_n = req.angle;
			end
			sdcp_pkg::KIND_STOP: spd_n = 8'd0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			held_spd_q <= 8'd0;
			held_ang_q <= sdcp_pkg::CENTER_RESET;
		end else begin
			if (pop) begin
				vld_q      <= 1'b1;
				held_spd_q <= spd_n;
				held_ang_q <= ang_n;
			end else if (res_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_kind  <= req.kind;
			res_speed <= spd_n;
			res_angle <= ang_n;
		end
	end

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_kind == sdcp_pkg::KIND_STOP |-> res_speed == 8'd0)
		else $error("stop result with non-zero speed");

	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_speed == held_spd_q && res_angle == held_ang_q)
		else $error("result differs from held values");

endmodule

// File: src/serial_drive_command_parser.sv
// Top level of the serial drive-command parser.
// Depends on sdcp_pkg, sdcp_front, sdcp_queue and sdcp_back.
//
// Takes one received byte per cycle on the s_ stream and frames messages
// on '*'; CR and LF are ignored. "#CMD,<speed>,<angle>" sets the held speed
// and angle, "#STOP" zeroes the speed, anything else leaves them alone.
// Every accepted '*' that fits in the frame gives exactly one result on the
// m_ stream: the message kind and the held speed and angle after it. A byte
// arriving when the frame already holds FRAME_BYTES-1 bytes is dropped and
// the frame restarts without a result. Throughput is one byte per cycle
// while s_tready is high; the front end scans each accepted byte. A
// result passes through a queue slot, then the output register, after its
// '*'. s_tready drops only when the QUEUE_DEPTH-entry queue is full,
// i.e. when results back up behind a stalled m_tready. center_angle (APB
// address 0) is the angle used when the angle field is missing or bad; it
// should be written only while the block is idle. Held angle resets to 90.
module serial_drive_command_parser #(
	parameter int FRAME_BYTES = sdcp_pkg::FRAME_BYTES_DEF,
	parameter int QUEUE_DEPTH = sdcp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] speed, [15:8] angle
	output logic [1:0]  m_tuser,   // [1:0] command_kind
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]       center_q;
	logic             q_full, q_not_empty, push, pop;
	sdcp_pkg::rec_t   push_rec, pop_rec;
	sdcp_pkg::kind_t  res_kind;
	logic [7:0]       res_speed, res_angle;
	logic             cfg_sel;

	// single register at byte address 0; the low address bits are ignored
	assign cfg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? {24'd0, center_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= sdcp_pkg::CENTER_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			center_q <= pwdata[7:0];
		end
	end

	// front takes bytes whenever the queue has room for a request
	assign s_tready = !q_full;

	sdcp_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s_tvalid),
		.byte_ready  (s_tready),
		.byte_data   (s_tdata),
		.center_angle(center_q),
		.push        (push),
		.push_rec    (push_rec)
	);

	sdcp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.pop_rec  (pop_rec)
	);

	sdcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(q_not_empty),
		.req      (pop_rec),
		.pop      (pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_kind (res_kind),
		.res_speed(res_speed),
		.res_angle(res_angle)
	);

	assign m_tdata = {res_angle, res_speed};
	assign m_tuser = res_kind;

endmodule
